### design/tcac_pkg.sv
// ----------------------------------------------------------------------------
// tcac_pkg: shared types and constants of the text console
// Word layouts, request kinds, character codes and the color lookup used by
// the escape parser.
// ----------------------------------------------------------------------------
package tcac_pkg;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;
   localparam int CELL_W      = 16;

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_COLOR = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [7:0] CHR_BS       = 8'h08;
   localparam logic [7:0] CHR_TAB      = 8'h09;
   localparam logic [7:0] CHR_LF       = 8'h0A;
   localparam logic [7:0] CHR_CR       = 8'h0D;
   localparam logic [7:0] CHR_ESC      = 8'h1B;
   localparam logic [7:0] CHR_SPACE    = 8'h20;
   localparam logic [7:0] CHR_ZERO     = 8'h30;
   localparam logic [7:0] CHR_NINE     = 8'h39;
   localparam logic [7:0] CHR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHR_M        = 8'h6D;

   localparam logic [CELL_W-1:0] BLANK_WHITE   = 16'h0F20;
   localparam logic [7:0]        COLOR_DEFAULT = 8'h0F;
   localparam logic [9:0]        VALUE_MAX     = 10'd1023;

   localparam logic [3:0] COLOR_LOW [8]  = '{4'd0, 4'd4, 4'd2, 4'd14,
                                             4'd1, 4'd5, 4'd3, 4'd15};
   localparam logic [3:0] COLOR_HIGH [8] = '{4'd7, 4'd12, 4'd10, 4'd14,
                                             4'd9, 4'd13, 4'd11, 4'd15};

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] cell_index;
      logic [3:0]  bg_color;
      logic [3:0]  fg_color;
      logic [7:0]  char_code;
   } req_type;

   // First field sits in the highest bits of the word.
   typedef struct packed {
      logic [15:0] cell_value;
      logic        escape_active;
      logic [7:0]  attribute;
      logic [10:0] cursor_pos;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic       feed;
      logic [7:0] code;
   } esc_cmd_type;

   typedef struct packed {
      logic       active;
      logic       set_color;
      logic [7:0] color;
   } esc_rsp_type;

   // Color after a completed sequence with value n; unknown values keep it.
   function automatic logic [7:0] sgr_color(input logic [9:0] n, input logic [7:0] cur);
      logic [7:0] c;
      logic [9:0] d;
      c = cur;
      d = '0;
      if (n == 10'd0) begin
         c = COLOR_DEFAULT;
      end else if (n inside {[10'd30:10'd37]}) begin
         d = n - 10'd30;
         c = {cur[7:4], COLOR_LOW[d[2:0]]};
      end else if (n inside {[10'd90:10'd97]}) begin
         d = n - 10'd90;
         c = {cur[7:4], COLOR_HIGH[d[2:0]]};
      end else if (n inside {[10'd40:10'd47]}) begin
         d = n - 10'd40;
         c = {COLOR_LOW[d[2:0]], cur[3:0]};
      end else if (n inside {[10'd100:10'd107]}) begin
         d = n - 10'd100;
         c = {COLOR_HIGH[d[2:0]], cur[3:0]};
      end
      return c;
   endfunction

endpackage

### design/tcac_ram.sv
// ----------------------------------------------------------------------------
// tcac_ram: text memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tcac_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tcac_pkg::CELL_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tcac_pkg::CELL_W-1:0] rd_data
);

   logic [tcac_pkg::CELL_W-1:0] mem_ff [DEPTH];
   logic [tcac_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tcac_esc.sv
// ----------------------------------------------------------------------------
// tcac_esc: color escape parser
// Tracks an open escape sequence, accumulates its decimal value and yields
// the new color when the closing byte arrives.
// ----------------------------------------------------------------------------
module tcac_esc #(
   parameter int ESCAPE_LIMIT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcac_pkg::esc_cmd_type cmd,
   input  logic [7:0]            color_cur,
   output tcac_pkg::esc_rsp_type rsp
);

   localparam int LEN_W = $clog2(ESCAPE_LIMIT + 1);

   logic             active_ff, active_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             bracket_ff, bracket_in;
   logic             ended_ff, ended_in;
   logic [9:0]       value_ff, value_in;
   logic [13:0]      value_next;

   assign value_next = 14'({value_ff, 3'b000}) + 14'({value_ff, 1'b0}) + 14'(cmd.code[3:0]);

   always_comb begin
      active_in     = active_ff;
      len_in        = len_ff;
      bracket_in    = bracket_ff;
      ended_in      = ended_ff;
      value_in      = value_ff;
      rsp.active    = active_ff;
      rsp.set_color = 1'b0;
      rsp.color     = color_cur;
      if (cmd.start) begin
         active_in = 1'b1;
      end else if (cmd.feed) begin
         if (32'(len_ff) >= ESCAPE_LIMIT || cmd.code == tcac_pkg::CHR_M) begin
            if (cmd.code == tcac_pkg::CHR_M && bracket_ff) begin
               rsp.set_color = 1'b1;
               rsp.color     = tcac_pkg::sgr_color(value_ff, color_cur);
            end
            active_in  = 1'b0;
            len_in     = '0;
            bracket_in = 1'b0;
            ended_in   = 1'b0;
            value_in   = '0;
         end else begin
            if (len_ff == '0) begin
               bracket_in = (cmd.code == tcac_pkg::CHR_LBRACKET);
            end else if (!ended_ff) begin
               if (cmd.code inside {[tcac_pkg::CHR_ZERO:tcac_pkg::CHR_NINE]}) begin
                  value_in = (value_next > 14'(tcac_pkg::VALUE_MAX)) ?
                             tcac_pkg::VALUE_MAX : value_next[9:0];
               end else begin
                  ended_in = 1'b1;
               end
            end
            len_in = len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         len_ff     <= '0;
         bracket_ff <= 1'b0;
         ended_ff   <= 1'b0;
         value_ff   <= '0;
      end else begin
         active_ff  <= active_in;
         len_ff     <= len_in;
         bracket_ff <= bracket_in;
         ended_ff   <= ended_in;
         value_ff   <= value_in;
      end
   end

endmodule

### design/tcac_seq.sv
// ----------------------------------------------------------------------------
// tcac_seq: console sequencer
// Holds the cursor and color, runs one request at a time against the text
// memory, and sweeps the memory for reset fill, clear and scroll.
// ----------------------------------------------------------------------------
module tcac_seq #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int ADDR_W  = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  tcac_pkg::req_type           req,
   output logic                        req_ready,
   input  logic                        slot_free,
   output logic                        emit,
   output tcac_pkg::rsp_type           result,
   output tcac_pkg::esc_cmd_type       esc_cmd,
   input  tcac_pkg::esc_rsp_type       esc_rsp,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [tcac_pkg::CELL_W-1:0] wr_data,
   output logic [ADDR_W-1:0]           rd_addr,
   input  logic [tcac_pkg::CELL_W-1:0] rd_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int MOVED = CELLS - COLUMNS;
   localparam int CNT_W = $clog2(CELLS + 1);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int CNX_W = $clog2(COLUMNS + 8);
   localparam int ROW_W = $clog2(ROWS);
   localparam int RNX_W = ROW_W + 1;

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_SCROLL = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0]                  state_ff, state_in;
   tcac_pkg::req_type           req_ff, req_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [7:0]                  color_ff, color_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tcac_pkg::CELL_W-1:0] cell_ff, cell_in;

   logic [ADDR_W-1:0]           row_base;
   logic [COL_W-1:0]            col_dec;
   logic [CNX_W-1:0]            tab_sum;
   logic [CNX_W-1:0]            col_nx;
   logic [RNX_W-1:0]            row_nx;
   logic [tcac_pkg::CELL_W-1:0] blank;

   assign row_base  = ADDR_W'(row_ff) * ADDR_W'(COLUMNS);
   assign col_dec   = (col_ff != '0) ? col_ff - 1'b1 : col_ff;
   assign tab_sum   = CNX_W'(col_ff) + CNX_W'(8);
   assign blank     = {color_ff, tcac_pkg::CHR_SPACE};
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      color_in = color_ff;
      cnt_in   = cnt_ff;
      cell_in  = cell_ff;
      col_nx   = CNX_W'(col_ff);
      row_nx   = RNX_W'(row_ff);
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = tcac_pkg::BLANK_WHITE;
      rd_addr  = '0;
      esc_cmd  = '0;
      emit     = 1'b0;
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(cnt_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req;
               cell_in  = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (req_ff.kind)
               tcac_pkg::KIND_PUT: begin
                  if (esc_rsp.active) begin
                     esc_cmd.feed = 1'b1;
                     esc_cmd.code = req_ff.char_code;
                     if (esc_rsp.set_color) begin
                        color_in = esc_rsp.color;
                     end
                     state_in = ST_EMIT;
                  end else begin
                     case (req_ff.char_code)
                        tcac_pkg::CHR_BS: begin
                           col_nx  = CNX_W'(col_dec);
                           wr_en   = 1'b1;
                           wr_addr = row_base + ADDR_W'(col_dec);
                           wr_data = blank;
                        end
                        tcac_pkg::CHR_TAB: begin
                           col_nx = {tab_sum[CNX_W-1:3], 3'b000};
                        end
                        tcac_pkg::CHR_LF: begin
                           col_nx = '0;
                           row_nx = RNX_W'(row_ff) + 1'b1;
                        end
                        tcac_pkg::CHR_CR: begin
                           col_nx = '0;
                        end
                        tcac_pkg::CHR_ESC: begin
                           esc_cmd.start = 1'b1;
                        end
                        default: begin
                           wr_en   = 1'b1;
                           wr_addr = row_base + ADDR_W'(col_ff);
                           wr_data = {color_ff, req_ff.char_code};
                           col_nx  = CNX_W'(col_ff) + 1'b1;
                        end
                     endcase
                     if (col_nx >= CNX_W'(COLUMNS)) begin
                        col_nx = '0;
                        row_nx = row_nx + 1'b1;
                     end
                     col_in = COL_W'(col_nx);
                     if (row_nx >= RNX_W'(ROWS)) begin
                        row_in   = ROW_W'(ROWS - 1);
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in   = ROW_W'(row_nx);
                        state_in = ST_EMIT;
                     end
                  end
               end
               tcac_pkg::KIND_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_CLEAR;
               end
               tcac_pkg::KIND_COLOR: begin
                  color_in = {req_ff.bg_color, req_ff.fg_color};
                  state_in = ST_EMIT;
               end
               default: begin
                  rd_addr  = ADDR_W'(req_ff.cell_index);
                  state_in = ST_READ;
               end
            endcase
         end
         ST_READ: begin
            cell_in  = (32'(req_ff.cell_index) < CELLS) ? rd_data : '0;
            state_in = ST_EMIT;
         end
         ST_SCROLL: begin
            // Reads run one cell ahead of the writes they feed.
            if (cnt_ff < CNT_W'(MOVED)) begin
               rd_addr = ADDR_W'(cnt_ff + CNT_W'(COLUMNS));
            end
            if (cnt_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(cnt_ff - 1'b1);
               wr_data = (cnt_ff <= CNT_W'(MOVED)) ? rd_data : blank;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELLS)) begin
               state_in = ST_EMIT;
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(cnt_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      result.cursor_col    = 7'(col_ff);
      result.cursor_row    = 5'(row_ff);
      result.cursor_pos    = 11'(row_base + ADDR_W'(col_ff));
      result.attribute     = color_ff;
      result.escape_active = esc_rsp.active;
      result.cell_value    = cell_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         col_ff   <= '0;
         row_ff   <= '0;
         color_ff <= tcac_pkg::COLOR_DEFAULT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         color_ff <= color_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      cell_ff <= cell_in;
   end

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (32'(col_ff) < COLUMNS && 32'(row_ff) < ROWS))
      else $error("cursor left the screen");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> 32'(wr_addr) < CELLS)
      else $error("text memory write out of range");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_EXEC)
      else $error("accepted word not executed");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCROLL |-> 32'(row_ff) == ROWS - 1)
      else $error("scroll with cursor off the last row");

   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      (emit && req_ff.kind != tcac_pkg::KIND_READ) |-> cell_ff == '0)
      else $error("cell value set for a non-read word");

endmodule

### design/text_console_ansi_color_top.sv
// ----------------------------------------------------------------------------
// text_console_ansi_color_top: character-cell console with color escapes
// Prints bytes into a text memory, moves and scrolls the cursor, parses
// color escape sequences and reports the cursor after every word.
//
//   channel | dir | tdata (low bit up)                                | tuser
//   req     | in  | char_code, fg_color, bg_color, cell_index, pad   | kind
//   rsp     | out | cursor_col, cursor_row, cursor_pos, attribute,   | -
//           |     | escape_active, cell_value                        |
//
// A word passes through accept, execute and hand to the output register; a
// cell read adds a read step before the hand-off. Clear and scroll each add a
// sweep over all COLUMNS*ROWS cells through the single text memory port pair.
// After reset a fill pass writes every cell blank before req_tready rises.
// A result waiting in the output register does not stop the next word from
// being accepted; the sequencer holds only when the register is still full.
// ----------------------------------------------------------------------------
module text_console_ansi_color_top #(
   parameter int COLUMNS      = 80,
   parameter int ROWS         = 25,
   parameter int ESCAPE_LIMIT = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // char_code[7:0], fg_color[11:8], bg_color[15:12], cell_index[26:16]
   input  logic [tcac_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cursor_col[6:0], cursor_row[11:7], cursor_pos[22:12], attribute[30:23],
   // escape_active[31], cell_value[47:32]
   output logic [tcac_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   tcac_pkg::req_type           req;
   tcac_pkg::rsp_type           result;
   tcac_pkg::esc_cmd_type       esc_cmd;
   tcac_pkg::esc_rsp_type       esc_rsp;
   logic                        emit;
   logic                        slot_free;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [tcac_pkg::CELL_W-1:0] wr_data;
   logic [ADDR_W-1:0]           rd_addr;
   logic [tcac_pkg::CELL_W-1:0] rd_data;

   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [tcac_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;

   always_comb begin
      req.kind       = req_tuser;
      req.char_code  = req_tdata[7:0];
      req.fg_color   = req_tdata[11:8];
      req.bg_color   = req_tdata[15:12];
      req.cell_index = req_tdata[26:16];
   end

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   tcac_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .slot_free (slot_free),
      .emit      (emit),
      .result    (result),
      .esc_cmd   (esc_cmd),
      .esc_rsp   (esc_rsp),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   tcac_esc #(
      .ESCAPE_LIMIT (ESCAPE_LIMIT)
   ) u_esc (
      .clock     (clock),
      .reset     (reset),
      .cmd       (esc_cmd),
      .color_cur (result.attribute),
      .rsp       (esc_rsp)
   );

   tcac_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tdata_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
